### hdl/text_console_cursor_scroll_defines.svh
// Assertion macros shared by the text console RTL.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define TCC_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// A condition that implies another in the same cycle.
`define TCC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that implies another in the next cycle.
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/tcc_pkg.sv
// Package with the types and constants of the text console.
`timescale 1ns / 1ps
package tcc_pkg;

   localparam int DEFAULT_COLS = 80;
   localparam int DEFAULT_ROWS = 25;
   localparam int CELL_W       = 16;

   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'h0F;

   typedef enum logic {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } tcc_opcode_type;

   typedef struct packed {
      tcc_opcode_type opcode;
      logic [7:0]     char_code;
      logic [4:0]     read_row;
      logic [6:0]     read_col;
   } tcc_req_type;

   typedef struct packed {
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic       scrolled;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } tcc_rsp_type;

endpackage

### hdl/text_console_cursor_scroll.sv
// Text console top level: cell store, cursor and scrolling.
//
//   Channel   Direction  Handshake             Carries
//   req_      in         req_valid/req_ready   tcc_req_type: opcode, char, cell to read
//   rsp_      out        rsp_valid/rsp_ready   tcc_rsp_type: cursor, scrolled, cell
//   csr_      in         csr_we                text attribute byte
//
// Without a scroll, the cell write and the cell read share the accept cycle, and the
// registered read of the RAM is taken up in ST_RESP. A scroll rotates the row offset
// and clears one row, one cell a cycle, in ST_CLEAR, then rereads in ST_REREAD. After
// reset a clearing pass writes all ROWS * COLS cells (2000 by default) before
// req_ready rises. The result register lets a new request enter while the previous
// result waits; it holds in ST_RESP while that register is full and rsp_ready is low.
`timescale 1ns / 1ps
module text_console_cursor_scroll #(
   parameter int COLS = tcc_pkg::DEFAULT_COLS,
   parameter int ROWS = tcc_pkg::DEFAULT_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcc_pkg::tcc_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tcc_pkg::tcc_rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [7:0]          csr_wdata
);

   import tcc_pkg::*;

   `include "text_console_cursor_scroll_defines.svh"

   localparam int DEPTH  = ROWS * COLS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_CLEAR  = 5'b00100,
      ST_REREAD = 5'b01000,
      ST_RESP   = 5'b10000
   } tcc_state_type;

   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
      logic [ROW_W:0]   sum;
      logic [ROW_W-1:0] prow;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      prow = sum[ROW_W-1:0];
      return ADDR_W'(prow * COLS) + ADDR_W'(col);
   endfunction

   tcc_state_type      state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [7:0]         attr_ff;
   tcc_req_type        req_ff, req_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               scr_ff, scr_in;
   logic               fwd_ff, fwd_in;
   logic [CELL_W-1:0]  fwd_data_ff, fwd_data_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  end_ff, end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tcc_rsp_type        rsp_ff, rsp_in;

   logic               accept;
   logic               is_put;
   logic               is_newline;
   logic [COL_W:0]     col_inc;
   logic               col_wrap;
   logic               adv_row;
   logic               row_last;
   logic               do_scroll;
   logic               wr_cell;
   logic [ROW_W-1:0]   top_inc;
   logic [ADDR_W-1:0]  top_base;
   tcc_req_type        rd_sel;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  cur_addr;
   logic               rd_in_range;
   logic               rsp_load;
   logic [CELL_W-1:0]  cell_sel;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [CELL_W-1:0]  ram_rdata;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_put     = (req_data.opcode == OP_PUT);
   assign is_newline = (req_data.char_code == NEWLINE_CODE);
   assign col_inc    = {1'b0, col_ff} + (COL_W+1)'(1);
   assign col_wrap   = (col_inc == (COL_W+1)'(COLS));
   assign adv_row    = is_put && (is_newline || col_wrap);
   assign row_last   = (row_ff == ROW_W'(ROWS - 1));
   assign do_scroll  = adv_row && row_last;
   assign wr_cell    = accept && is_put && !is_newline;
   assign top_inc    = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + ROW_W'(1);
   assign top_base   = ADDR_W'(top_ff * COLS);

   assign rd_sel      = (state_ff == ST_REREAD) ? req_ff : req_data;
   assign rd_addr     = phys_addr(ROW_W'(rd_sel.read_row), COL_W'(rd_sel.read_col), top_ff);
   assign cur_addr    = phys_addr(row_ff, col_ff, top_ff);
   assign rd_in_range = (32'(req_data.read_row) < ROWS) && (32'(req_data.read_col) < COLS);

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
   assign cell_sel = fwd_ff ? fwd_data_ff : ram_rdata;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = {attr_ff, SPACE_CODE};
      ram_re    = 1'b0;
      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = {RESET_ATTR, SPACE_CODE};
         end
         ST_IDLE: begin
            ram_we    = wr_cell;
            ram_waddr = cur_addr;
            ram_wdata = {attr_ff, req_data.char_code};
            ram_re    = accept;
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_REREAD: begin
            ram_re = 1'b1;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      req_in       = req_ff;
      rd_ok_in     = rd_ok_ff;
      scr_in       = scr_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      clr_in       = clr_ff;
      end_in       = end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_INIT: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               rd_ok_in    = rd_in_range;
               scr_in      = do_scroll;
               fwd_in      = wr_cell && (cur_addr == rd_addr);
               fwd_data_in = ram_wdata;
               if (is_put) begin
                  col_in = (is_newline || col_wrap) ? '0 : col_inc[COL_W-1:0];
               end
               if (adv_row && !row_last) begin
                  row_in = row_ff + ROW_W'(1);
               end
               if (do_scroll) begin
                  top_in   = top_inc;
                  clr_in   = top_base;
                  end_in   = top_base + ADDR_W'(COLS - 1);
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == end_ff) begin
               state_in = ST_REREAD;
            end
         end
         ST_REREAD: begin
            fwd_in   = 1'b0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_in.cursor_row = 5'(row_ff);
               rsp_in.cursor_col = 7'(col_ff);
               rsp_in.scrolled   = scr_ff;
               rsp_in.cell_char  = rd_ok_ff ? cell_sel[7:0] : 8'h00;
               rsp_in.cell_attr  = rd_ok_ff ? cell_sel[15:8] : 8'h00;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         clr_ff       <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         clr_ff       <= clr_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= fwd_in;
         if (csr_we) begin
            attr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_ok_ff    <= rd_ok_in;
      scr_ff      <= scr_in;
      fwd_data_ff <= fwd_data_in;
      rsp_ff      <= rsp_in;
   end

   tcc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCC_ASSERT_HOLDS(a_cursor_in_range, clock, reset, (32'(row_ff) < ROWS) && (32'(col_ff) < COLS), "Cursor left the screen.")
   `TCC_ASSERT_NEXT(a_accept_moves_on, clock, reset, accept, (state_ff == ST_RESP) || (state_ff == ST_CLEAR), "Accepted transfer did not start its work.")
   `TCC_ASSERT_IMPLIES(a_clear_last_row, clock, reset, state_ff == ST_CLEAR, (row_ff == ROW_W'(ROWS - 1)) && (clr_ff <= end_ff), "Row clear out of bounds.")
   `TCC_ASSERT_IMPLIES(a_rsp_from_resp, clock, reset, $rose(rsp_valid), $past(state_ff == ST_RESP), "Result appeared outside the response step.")

endmodule

### hdl/tcc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
